@@ sv/twban_pkg.sv @@
package twban_pkg;

    localparam int WORD_W   = 32;
    localparam int RANK_W   = 4;
    localparam int LEN_W    = 6;
    localparam int META_W   = 2;
    localparam int PHASE_W  = 3;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int N_META   = 4;

    localparam logic [RANK_W-1:0] RANK_RST = 4'd15;
    localparam logic [LEN_W-1:0]  LEN0_RST = 6'd8;
    localparam logic [LEN_W-1:0]  LEN1_RST = 6'd16;
    localparam logic [LEN_W-1:0]  LEN2_RST = 6'd24;
    localparam logic [LEN_W-1:0]  LEN3_RST = 6'd32;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE = 3'd0,
        PH_ARB  = 3'd1,
        PH_META = 3'd2,
        PH_DATA = 3'd3,
        PH_FIN  = 3'd4
    } t_phase;

    typedef enum logic {
        HS_READ  = 1'b0,
        HS_WRITE = 1'b1
    } t_half;

    typedef enum logic [1:0] {
        OP_POLL  = 2'd0,
        OP_LATCH = 2'd1,
        OP_ALERT = 2'd2,
        OP_QUEUE = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        REG_NODE_RANK = 3'd0,
        REG_LEN_META0 = 3'd1,
        REG_LEN_META1 = 3'd2,
        REG_LEN_META2 = 3'd3,
        REG_LEN_META3 = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [RANK_W-1:0]             node_rank;
        logic [N_META-1:0][LEN_W-1:0]  len_tab;
    } t_cfg;

    typedef struct packed {
        logic                data_drive;
        logic                alert_drive;
        logic                latch_drive;
        logic                message_done;
        logic                was_sender;
        logic [RANK_W-1:0]   winner_rank;
        logic [META_W-1:0]   received_meta;
        logic [WORD_W-1:0]   received_payload;
        logic [PHASE_W-1:0]  bus_phase;
        logic                message_queued;
    } t_res;

endpackage

@@ sv/twban_if.sv @@
interface twban_evt_if import twban_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic               alert_level;
    logic               latch_level;
    logic               data_sample;
    logic [META_W-1:0]  send_meta;
    logic [WORD_W-1:0]  send_payload;

    modport source (output valid, output opcode, output alert_level, output latch_level,
                    output data_sample, output send_meta, output send_payload,
                    input ready);
    modport sink   (input valid, input opcode, input alert_level, input latch_level,
                    input data_sample, input send_meta, input send_payload,
                    output ready);
endinterface

interface twban_res_if import twban_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                data_drive;
    logic                alert_drive;
    logic                latch_drive;
    logic                message_done;
    logic                was_sender;
    logic [RANK_W-1:0]   winner_rank;
    logic [META_W-1:0]   received_meta;
    logic [WORD_W-1:0]   received_payload;
    logic [PHASE_W-1:0]  bus_phase;
    logic                message_queued;

    modport source (output valid, output data_drive, output alert_drive, output latch_drive,
                    output message_done, output was_sender, output winner_rank,
                    output received_meta, output received_payload, output bus_phase,
                    output message_queued, input ready);
    modport sink   (input valid, input data_drive, input alert_drive, input latch_drive,
                    input message_done, input was_sender, input winner_rank,
                    input received_meta, input received_payload, input bus_phase,
                    input message_queued, output ready);
endinterface

@@ sv/twban_regs.sv @@
module twban_regs import twban_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_rank  <= RANK_RST;
            r_cfg.len_tab[0] <= LEN0_RST;
            r_cfg.len_tab[1] <= LEN1_RST;
            r_cfg.len_tab[2] <= LEN2_RST;
            r_cfg.len_tab[3] <= LEN3_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_NODE_RANK: r_cfg.node_rank  <= pwdata[RANK_W-1:0];
                REG_LEN_META0: r_cfg.len_tab[0] <= pwdata[LEN_W-1:0];
                REG_LEN_META1: r_cfg.len_tab[1] <= pwdata[LEN_W-1:0];
                REG_LEN_META2: r_cfg.len_tab[2] <= pwdata[LEN_W-1:0];
                REG_LEN_META3: r_cfg.len_tab[3] <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Reads return the stored value, zero extended; unused addresses read as zero.
    always_comb begin
        case (w_idx)
            REG_NODE_RANK: prdata = APB_DW'(r_cfg.node_rank);
            REG_LEN_META0: prdata = APB_DW'(r_cfg.len_tab[0]);
            REG_LEN_META1: prdata = APB_DW'(r_cfg.len_tab[1]);
            REG_LEN_META2: prdata = APB_DW'(r_cfg.len_tab[2]);
            REG_LEN_META3: prdata = APB_DW'(r_cfg.len_tab[3]);
            default:       prdata = '0;
        endcase
    end

endmodule

@@ sv/three_wire_bus_arbitration_node.sv @@
// Channel   Direction  Contents
// i_evt     in         line event: opcode, alert/latch levels, data sample, message to queue
// o_res     out        line drives, message_done with the received rank/meta/payload, phase
// APB       in/out     node_rank and the four payload length registers
//
// Every event is handled at the edge its transfer completes: the state advances there,
// and its result is loaded into the output register at the same edge.
// One event per clock is sustained while o_res does not stall; the output register
// takes a new result whenever it is empty or its current result leaves in the same cycle.
// Reset is synchronous and active low; it returns the node to idle with all lines released.
// Stalls on o_res hold the result and stop new events; nothing is lost or repeated.
module three_wire_bus_arbitration_node import twban_pkg::*; #(
    parameter int RANK_BITS        = 4,
    parameter int META_WIDTH       = 2,
    parameter int MAX_PAYLOAD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    twban_evt_if.sink          i_evt,
    twban_res_if.source        o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    // Derived constants for the arbitration and meta fields.
    localparam logic [WORD_W-1:0] RANK_MASK  = WORD_W'((64'd1 << RANK_BITS) - 64'd1);
    localparam logic [2:0]        ARB_IDX0   = 3'((RANK_BITS - 1) & 7);
    localparam logic [WORD_W-1:0] ARB_MASK0  = WORD_W'(1) << ARB_IDX0;
    localparam logic [WORD_W-1:0] META_MASK0 = WORD_W'(1) << (META_WIDTH - 1);
    localparam logic [LEN_W-1:0]  LEN_MAX    = LEN_W'(MAX_PAYLOAD_BITS);
    localparam int                LEN_SH_W   = $clog2(MAX_PAYLOAD_BITS);
    localparam logic [WORD_W-1:0] ALL_ONES   = '1;

    t_cfg w_cfg;

    twban_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Node state.
    t_phase                r_phase,   n_phase;
    t_half                 r_half,    n_half;
    logic                  r_sender,  n_sender;
    logic                  r_pend,    n_pend;
    logic [META_W-1:0]     r_pmeta,   n_pmeta;
    logic [WORD_W-1:0]     r_ppay,    n_ppay;
    logic [WORD_W-1:0]     r_send,    n_send;
    logic [WORD_W-1:0]     r_recv,    n_recv;
    logic [WORD_W-1:0]     r_mask,    n_mask;
    logic [2:0]            r_arb_idx, n_arb_idx;
    logic [RANK_W-1:0]     r_arb_res, n_arb_res;
    logic [META_WIDTH-1:0] r_meta,    n_meta;
    logic                  r_data_drv,  n_data_drv;
    logic                  r_alert_drv, n_alert_drv;
    logic                  r_latch_drv, n_latch_drv;

    // Output register.
    logic r_out_valid;
    t_res r_res, n_res;

    logic                  w_accept;
    logic                  w_busy;
    t_opcode               w_op;
    logic [WORD_W-1:0]     w_rank;
    logic [WORD_W-1:0]     w_recv_sh;
    logic [WORD_W-1:0]     w_mask_sh;
    logic                  w_arb_miss;
    logic [META_WIDTH-1:0] w_meta_new;
    logic [1:0]            w_len_sel;
    logic [LEN_W-1:0]      w_len_raw;
    logic [LEN_W-1:0]      w_len_eff;
    logic [LEN_SH_W-1:0]   w_len_sh;
    logic                  w_done;

    // The input is taken whenever the output register can take the result.
    assign i_evt.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_evt.valid && i_evt.ready;
    assign w_op        = t_opcode'(i_evt.opcode);
    assign w_busy      = (r_phase == PH_ARB) || (r_phase == PH_META) || (r_phase == PH_DATA);

    // Bit read on a latch edge: shift the sample in and step the mask.
    assign w_rank     = RANK_MASK & WORD_W'(w_cfg.node_rank);
    assign w_recv_sh  = {r_recv[WORD_W-2:0], i_evt.data_sample};
    assign w_mask_sh  = r_mask >> 1;
    assign w_arb_miss = w_recv_sh != (w_rank >> r_arb_idx);

    // Payload length lookup for the meta value just completed; the table entry is
    // clamped to 1..MAX_PAYLOAD_BITS, and meta values above three use the last entry.
    assign w_meta_new = w_recv_sh[META_WIDTH-1:0];
    assign w_len_sel  = (WORD_W'(w_meta_new) > WORD_W'(3)) ? 2'd3 : 2'(w_meta_new);
    assign w_len_raw  = w_cfg.len_tab[w_len_sel];
    always_comb begin
        if (w_len_raw == '0) begin
            w_len_eff = LEN_W'(1);
        end else if (w_len_raw > LEN_MAX) begin
            w_len_eff = LEN_MAX;
        end else begin
            w_len_eff = w_len_raw;
        end
    end
    assign w_len_sh = LEN_SH_W'(w_len_eff - LEN_W'(1));

    // Next state of the node for the accepted event.
    always_comb begin
        n_phase     = r_phase;
        n_half      = r_half;
        n_sender    = r_sender;
        n_pend      = r_pend;
        n_pmeta     = r_pmeta;
        n_ppay      = r_ppay;
        n_send      = r_send;
        n_recv      = r_recv;
        n_mask      = r_mask;
        n_arb_idx   = r_arb_idx;
        n_arb_res   = r_arb_res;
        n_meta      = r_meta;
        n_data_drv  = r_data_drv;
        n_alert_drv = r_alert_drv;
        n_latch_drv = r_latch_drv;
        if (w_accept) begin
            case (w_op)
                OP_POLL: begin
                    if (r_phase == PH_IDLE) begin
                        // Another node pulling alert low, or our own queued message,
                        // opens a new message with the arbitration field.
                        if (!i_evt.alert_level || r_pend) begin
                            n_alert_drv = 1'b0;
                            n_latch_drv = 1'b1;
                            n_arb_res   = '0;
                            n_arb_idx   = ARB_IDX0;
                            n_mask      = ARB_MASK0;
                            n_recv      = '0;
                            n_send      = r_pend ? w_rank : ALL_ONES;
                            n_sender    = r_pend;
                            n_data_drv  = |((r_pend ? w_rank : ALL_ONES) & ARB_MASK0);
                            n_phase     = PH_ARB;
                            n_half      = HS_READ;
                        end
                    end else if (r_phase == PH_FIN) begin
                        if (i_evt.alert_level && !i_evt.latch_level) begin
                            n_data_drv = 1'b1;
                            n_phase    = PH_IDLE;
                        end
                    end
                end
                OP_LATCH: begin
                    if (w_busy && r_half == HS_READ) begin
                        n_recv      = w_recv_sh;
                        n_mask      = w_mask_sh;
                        n_latch_drv = 1'b0;
                        n_alert_drv = 1'b1;
                        n_half      = HS_WRITE;
                        case (r_phase)
                            PH_ARB: begin
                                // Losing arbitration turns the node into a receiver.
                                if (w_arb_miss) begin
                                    n_sender = 1'b0;
                                    n_send   = ALL_ONES;
                                end
                                n_arb_idx = r_arb_idx - 3'd1;
                                if (w_mask_sh == '0) begin
                                    n_send    = n_sender ? WORD_W'(r_pmeta) : ALL_ONES;
                                    n_arb_res = w_recv_sh[RANK_W-1:0];
                                    n_recv    = '0;
                                    n_mask    = META_MASK0;
                                    n_phase   = PH_META;
                                end
                            end
                            PH_META: begin
                                if (w_mask_sh == '0) begin
                                    if (r_sender) begin
                                        n_send = r_ppay;
                                    end
                                    n_meta  = w_meta_new;
                                    n_recv  = '0;
                                    n_mask  = WORD_W'(1) << w_len_sh;
                                    n_phase = PH_DATA;
                                end
                            end
                            default: begin
                                if (w_mask_sh == '0) begin
                                    if (r_sender) begin
                                        n_pend = 1'b0;
                                    end
                                    n_phase = PH_FIN;
                                end
                            end
                        endcase
                    end
                end
                OP_ALERT: begin
                    if (w_busy && r_half == HS_WRITE) begin
                        n_data_drv  = |(r_send & r_mask);
                        n_alert_drv = 1'b0;
                        n_latch_drv = 1'b1;
                        n_half      = HS_READ;
                    end
                end
                OP_QUEUE: begin
                    // A second message is dropped while one is still pending.
                    if (!r_pend) begin
                        n_pend  = 1'b1;
                        n_pmeta = i_evt.send_meta;
                        n_ppay  = i_evt.send_payload;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result item for the accepted event, taken from the updated state.
    assign w_done = (w_op == OP_POLL) && (r_phase == PH_FIN)
                    && i_evt.alert_level && !i_evt.latch_level;

    always_comb begin
        n_res                  = '0;
        n_res.data_drive       = n_data_drv;
        n_res.alert_drive      = n_alert_drv;
        n_res.latch_drive      = n_latch_drv;
        n_res.message_done     = w_done;
        n_res.bus_phase        = n_phase;
        n_res.message_queued   = n_pend;
        if (w_done) begin
            n_res.was_sender       = n_sender;
            n_res.winner_rank      = n_arb_res;
            n_res.received_meta    = META_W'(n_meta);
            n_res.received_payload = n_recv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_half      <= HS_READ;
            r_sender    <= 1'b0;
            r_pend      <= 1'b0;
            r_pmeta     <= '0;
            r_ppay      <= '0;
            r_send      <= ALL_ONES;
            r_recv      <= '0;
            r_mask      <= '0;
            r_arb_idx   <= '0;
            r_arb_res   <= '0;
            r_meta      <= '0;
            r_data_drv  <= 1'b1;
            r_alert_drv <= 1'b1;
            r_latch_drv <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_half      <= n_half;
            r_sender    <= n_sender;
            r_pend      <= n_pend;
            r_pmeta     <= n_pmeta;
            r_ppay      <= n_ppay;
            r_send      <= n_send;
            r_recv      <= n_recv;
            r_mask      <= n_mask;
            r_arb_idx   <= n_arb_idx;
            r_arb_res   <= n_arb_res;
            r_meta      <= n_meta;
            r_data_drv  <= n_data_drv;
            r_alert_drv <= n_alert_drv;
            r_latch_drv <= n_latch_drv;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.data_drive       = r_res.data_drive;
    assign o_res.alert_drive      = r_res.alert_drive;
    assign o_res.latch_drive      = r_res.latch_drive;
    assign o_res.message_done     = r_res.message_done;
    assign o_res.was_sender       = r_res.was_sender;
    assign o_res.winner_rank      = r_res.winner_rank;
    assign o_res.received_meta    = r_res.received_meta;
    assign o_res.received_payload = r_res.received_payload;
    assign o_res.bus_phase        = r_res.bus_phase;
    assign o_res.message_queued   = r_res.message_queued;

    // A finished message always leaves the node idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.message_done) |-> (r_res.bus_phase == PH_IDLE))
        else $error("message_done reported outside the idle phase");

    // While a message runs, latch is released exactly in the read half-step and
    // alert is always driven opposite to latch.
    a_half_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ARB || r_phase == PH_META || r_phase == PH_DATA)
        |-> ((r_latch_drv == (r_half == HS_READ)) && (r_alert_drv != r_latch_drv)))
        else $error("line drives do not match the half-step");

    // The bit pointer selects exactly one bit while a field is in progress.
    a_mask_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ARB || r_phase == PH_META || r_phase == PH_DATA)
        |-> $onehot(r_mask))
        else $error("bit mask lost its single bit during a message");

endmodule

@@ tb/node_check_pkg.sv @@
package node_check_pkg;
    import twban_pkg::*;

    // Tracks what one bus node should do for every accepted line event and
    // compares the node's results against that, oldest first.
    class node_scoreboard;
        logic [RANK_W-1:0] rank;
        logic [LEN_W-1:0]  len_tab [N_META];

        t_phase            phase;
        t_half             half;
        bit                sender;
        bit                msg_pending;
        logic [META_W-1:0] pend_meta;
        logic [WORD_W-1:0] pend_payload;
        logic [WORD_W-1:0] tx_shift;
        logic [WORD_W-1:0] rx_shift;
        logic [WORD_W-1:0] bit_sel;
        logic [2:0]        arb_idx;
        logic [RANK_W-1:0] arb_rank;
        logic [META_W-1:0] rx_meta;
        bit                drv_data;
        bit                drv_alert;
        bit                drv_latch;

        t_res              outputs_due [$];
        int                n_errors;
        int                n_messages;
        int                n_sent;

        function void reset_state();
            rank         = RANK_RST;
            len_tab[0]   = LEN0_RST;
            len_tab[1]   = LEN1_RST;
            len_tab[2]   = LEN2_RST;
            len_tab[3]   = LEN3_RST;
            phase        = PH_IDLE;
            half         = HS_READ;
            sender       = 1'b0;
            msg_pending  = 1'b0;
            pend_meta    = '0;
            pend_payload = '0;
            tx_shift     = '1;
            rx_shift     = '0;
            bit_sel      = '0;
            arb_idx      = '0;
            arb_rank     = '0;
            rx_meta      = '0;
            drv_data     = 1'b1;
            drv_alert    = 1'b1;
            drv_latch    = 1'b1;
        endfunction

        function void write_reg(t_reg_idx idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_NODE_RANK: rank       = value[RANK_W-1:0];
                REG_LEN_META0: len_tab[0] = value[LEN_W-1:0];
                REG_LEN_META1: len_tab[1] = value[LEN_W-1:0];
                REG_LEN_META2: len_tab[2] = value[LEN_W-1:0];
                default:       len_tab[3] = value[LEN_W-1:0];
            endcase
        endfunction

        function void note_event(t_opcode op, bit alert_lvl, bit latch_lvl, bit sample,
                                 logic [META_W-1:0] meta, logic [WORD_W-1:0] payload);
            t_res r;
            bit   done;
            bit   busy;
            int   len;
            done = 1'b0;
            busy = (phase == PH_ARB) || (phase == PH_META) || (phase == PH_DATA);
            case (op)
                OP_POLL: begin
                    if (phase == PH_IDLE) begin
                        // A low alert line or our own queued message opens a message.
                        if (!alert_lvl || msg_pending) begin
                            drv_alert = 1'b0;
                            arb_rank  = '0;
                            arb_idx   = 3'(RANK_W - 1);
                            bit_sel   = 32'd1 << arb_idx;
                            rx_shift  = '0;
                            if (msg_pending) begin
                                tx_shift = {{(WORD_W-RANK_W){1'b0}}, rank};
                                sender   = 1'b1;
                            end else begin
                                tx_shift = '1;
                                sender   = 1'b0;
                            end
                            drv_data  = |(tx_shift & bit_sel);
                            drv_latch = 1'b1;
                            phase     = PH_ARB;
                            half      = HS_READ;
                        end
                    end else if (phase == PH_FIN) begin
                        if (alert_lvl && !latch_lvl) begin
                            drv_data = 1'b1;
                            phase    = PH_IDLE;
                            done     = 1'b1;
                        end
                    end
                end
                OP_LATCH: begin
                    if (busy && half == HS_READ) begin
                        rx_shift  = {rx_shift[WORD_W-2:0], sample};
                        bit_sel   = bit_sel >> 1;
                        drv_latch = 1'b0;
                        drv_alert = 1'b1;
                        half      = HS_WRITE;
                        case (phase)
                            PH_ARB: begin
                                // Any bit that differs from our rank prefix means we lost.
                                if (rx_shift != ({{(WORD_W-RANK_W){1'b0}}, rank} >> arb_idx)) begin
                                    sender   = 1'b0;
                                    tx_shift = '1;
                                end
                                arb_idx = arb_idx - 3'd1;
                                if (bit_sel == '0) begin
                                    tx_shift = sender ? {{(WORD_W-META_W){1'b0}}, pend_meta} : '1;
                                    arb_rank = rx_shift[RANK_W-1:0];
                                    rx_shift = '0;
                                    bit_sel  = 32'd1 << (META_W - 1);
                                    phase    = PH_META;
                                end
                            end
                            PH_META: begin
                                if (bit_sel == '0) begin
                                    if (sender) tx_shift = pend_payload;
                                    rx_meta  = rx_shift[META_W-1:0];
                                    rx_shift = '0;
                                    // Lengths of zero or beyond the word are clamped.
                                    len = int'(len_tab[rx_meta]);
                                    if (len < 1) len = 1;
                                    else if (len > WORD_W) len = WORD_W;
                                    bit_sel = 32'd1 << (len - 1);
                                    phase   = PH_DATA;
                                end
                            end
                            default: begin
                                if (bit_sel == '0) begin
                                    if (sender) msg_pending = 1'b0;
                                    phase = PH_FIN;
                                end
                            end
                        endcase
                    end
                end
                OP_ALERT: begin
                    if (busy && half == HS_WRITE) begin
                        drv_data  = |(tx_shift & bit_sel);
                        drv_alert = 1'b0;
                        drv_latch = 1'b1;
                        half      = HS_READ;
                    end
                end
                default: begin
                    // Only the first queued message is kept.
                    if (!msg_pending) begin
                        msg_pending  = 1'b1;
                        pend_meta    = meta;
                        pend_payload = payload;
                    end
                end
            endcase

            r.data_drive       = drv_data;
            r.alert_drive      = drv_alert;
            r.latch_drive      = drv_latch;
            r.message_done     = done;
            r.was_sender       = done & sender;
            r.winner_rank      = done ? arb_rank : '0;
            r.received_meta    = done ? rx_meta : '0;
            r.received_payload = done ? rx_shift : '0;
            r.bus_phase        = phase;
            r.message_queued   = msg_pending;
            outputs_due.push_back(r);
            if (done) begin
                n_messages++;
                if (sender) n_sent++;
            end
        endfunction

        function void compare_field(string name, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                n_errors++;
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (outputs_due.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, got);
                n_errors++;
                return;
            end
            want = outputs_due.pop_front();
            compare_field("data_drive", want.data_drive, got.data_drive);
            compare_field("alert_drive", want.alert_drive, got.alert_drive);
            compare_field("latch_drive", want.latch_drive, got.latch_drive);
            compare_field("message_done", want.message_done, got.message_done);
            compare_field("was_sender", want.was_sender, got.was_sender);
            compare_field("winner_rank", want.winner_rank, got.winner_rank);
            compare_field("received_meta", want.received_meta, got.received_meta);
            compare_field("received_payload", want.received_payload, got.received_payload);
            compare_field("bus_phase", want.bus_phase, got.bus_phase);
            compare_field("message_queued", want.message_queued, got.message_queued);
        endfunction
    endclass

endpackage

@@ tb/tb_three_wire_bus_arbitration_node.sv @@
module tb_three_wire_bus_arbitration_node;
    import twban_pkg::*;
    import node_check_pkg::*;

    // Cycles without any transfer before the run is declared hung. The slowest
    // correct stretch is the long receiver hold plus a few gaps and a config load.
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 120;
    localparam int ITEMS_TARGET = 1600;
    localparam int N_SETTINGS   = 8;
    localparam int TAIL_CYCLES  = 8;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    twban_evt_if evt_if ();
    twban_res_if res_if ();

    node_scoreboard sb;

    int idle_cycles   = 0;
    int items_sent    = 0;
    int noise_count   = 0;
    bit hold_request  = 1'b0;
    bit sender_burst  = 1'b0;
    bit recv_burst    = 1'b0;

    three_wire_bus_arbitration_node i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Payload lengths stay short most of the time so that many messages fit in
    // the run; now and then a value outside 1..32 exercises the clamping.
    function automatic logic [LEN_W-1:0] rand_len();
        if ($urandom_range(0, 7) == 0) return LEN_W'($urandom_range(0, 63));
        return LEN_W'($urandom_range(1, 8));
    endfunction

    // Offers one line event and returns at the falling edge after its transfer.
    // valid is left high so a back-to-back event does not toggle it; a gap
    // lowers it first.
    task automatic send_event(t_opcode op, bit alert_lvl, bit latch_lvl, bit sample,
                              logic [META_W-1:0] meta, logic [WORD_W-1:0] payload);
        int gap;
        if ($urandom_range(0, 63) == 0) sender_burst = !sender_burst;
        gap = sender_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            evt_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        evt_if.valid        <= 1'b1;
        evt_if.opcode       <= op;
        evt_if.alert_level  <= alert_lvl;
        evt_if.latch_level  <= latch_lvl;
        evt_if.data_sample  <= sample;
        evt_if.send_meta    <= meta;
        evt_if.send_payload <= payload;
        @(posedge i_clk);
        while (!evt_if.ready) @(posedge i_clk);
        sb.note_event(op, alert_lvl, latch_lvl, sample, meta, payload);
        items_sent++;
        // Twice in the run the receiver is asked to hold off for a long while
        // so that the output register fills and the input side stalls.
        if (items_sent == 400 || items_sent == 1100) hold_request = 1'b1;
        @(negedge i_clk);
    endtask

    // A fully random event; out-of-turn edges and busy polls come from here.
    task automatic send_noise();
        noise_count++;
        send_event(t_opcode'($urandom_range(0, 3)), coin(), coin(), coin(),
                   META_W'($urandom_range(0, 3)), $urandom());
    endtask

    // Drives the node from whatever phase it is in back to idle with a
    // well-formed sequence of edges. In the read half-step the sampled data
    // is our own drive wired-AND with the other nodes; lose_pct sets how often
    // another node pulls the line low against a sending node.
    task automatic run_message(int lose_pct, bit noisy);
        bit other;
        if (sb.phase == PH_IDLE) begin
            send_event(OP_POLL, sb.msg_pending ? coin() : 1'b0, coin(), coin(),
                       META_W'($urandom_range(0, 3)), $urandom());
        end
        while (sb.phase != PH_IDLE) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                send_noise();
            end else if (sb.phase == PH_FIN) begin
                // Mostly the release condition, sometimes levels that keep it waiting.
                if ($urandom_range(0, 3) != 0) begin
                    send_event(OP_POLL, 1'b1, 1'b0, coin(), META_W'($urandom_range(0, 3)),
                               $urandom());
                end else begin
                    send_event(OP_POLL, coin(), coin(), coin(), META_W'($urandom_range(0, 3)),
                               $urandom());
                end
            end else if (sb.half == HS_READ) begin
                if (!sb.sender || $urandom_range(0, 99) < lose_pct) other = coin();
                else other = 1'b1;
                send_event(OP_LATCH, coin(), coin(), sb.drv_data & other,
                           META_W'($urandom_range(0, 3)), $urandom());
            end else begin
                send_event(OP_ALERT, coin(), coin(), coin(), META_W'($urandom_range(0, 3)),
                           $urandom());
            end
        end
    endtask

    // Stops offering events and waits until every expected result has had
    // its transfer.
    task automatic wait_for_results();
        evt_if.valid <= 1'b0;
        while (sb.outputs_due.size() != 0) @(negedge i_clk);
    endtask

    // One APB write: a setup phase, then the access phase that completes at the
    // rising edge with pready high. psel is left high so that writes can follow
    // each other without a gap.
    task automatic apb_write(t_reg_idx idx, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, value);
        @(negedge i_clk);
    endtask

    // Loads a full setting while the node has nothing in flight.
    task automatic load_config(logic [RANK_W-1:0] rank, logic [LEN_W-1:0] len0,
                               logic [LEN_W-1:0] len1, logic [LEN_W-1:0] len2,
                               logic [LEN_W-1:0] len3);
        wait_for_results();
        apb_write(REG_NODE_RANK, APB_DW'(rank));
        apb_write(REG_LEN_META0, APB_DW'(len0));
        apb_write(REG_LEN_META1, APB_DW'(len1));
        apb_write(REG_LEN_META2, APB_DW'(len2));
        apb_write(REG_LEN_META3, APB_DW'(len3));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: before each transfer the receiver waits a random number of
    // cycles, or none during a burst stretch, or the long hold when asked.
    initial begin
        int w;
        res_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                w = HOLD_CYCLES;
            end else begin
                if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
                w = recv_burst ? 0 : $urandom_range(0, 5);
            end
            if (w > 0) begin
                res_if.ready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Every result transfer is checked at the rising edge where it happens.
    // The same process counts cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n === 1'b1) begin
            if (res_if.valid && res_if.ready) begin
                got.data_drive       = res_if.data_drive;
                got.alert_drive      = res_if.alert_drive;
                got.latch_drive      = res_if.latch_drive;
                got.message_done     = res_if.message_done;
                got.was_sender       = res_if.was_sender;
                got.winner_rank      = res_if.winner_rank;
                got.received_meta    = res_if.received_meta;
                got.received_payload = res_if.received_payload;
                got.bus_phase        = res_if.bus_phase;
                got.message_queued   = res_if.message_queued;
                sb.check_result(got);
            end
            if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, sb.outputs_due.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        int phase_idx;
        int phase_end;
        int pick;
        sb = new();
        sb.reset_state();
        i_rst_n             <= 1'b0;
        evt_if.valid        <= 1'b0;
        evt_if.opcode       <= OP_POLL;
        evt_if.alert_level  <= 1'b1;
        evt_if.latch_level  <= 1'b0;
        evt_if.data_sample  <= 1'b1;
        evt_if.send_meta    <= '0;
        evt_if.send_payload <= '0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. Rank 0 and the table extremes, with a zero length and
        // one above the word size to check the clamping.
        load_config(4'd0, 6'd1, 6'd32, 6'd0, 6'd63);
        // Alert high with nothing queued keeps the node idle.
        send_event(OP_POLL, 1'b1, 1'b0, 1'b0, 2'd0, 32'h0);
        // Edges outside a message are ignored.
        send_event(OP_LATCH, 1'b1, 1'b1, 1'b1, 2'd3, 32'hFFFF_FFFF);
        send_event(OP_ALERT, 1'b0, 1'b0, 1'b1, 2'd0, 32'h0);
        // Queue a message; a second request while it waits is dropped.
        send_event(OP_QUEUE, 1'b0, 1'b0, 1'b0, 2'd0, 32'hFFFF_FFFF);
        send_event(OP_QUEUE, 1'b1, 1'b1, 1'b1, 2'd3, 32'h0);
        // The queued message starts the bus even though alert reads high.
        send_event(OP_POLL, 1'b1, 1'b1, 1'b0, 2'd1, 32'h0);
        // An alert edge in the read half-step and a poll while busy do nothing.
        send_event(OP_ALERT, 1'b1, 1'b0, 1'b0, 2'd2, 32'hA5A5_5A5A);
        send_event(OP_POLL, 1'b0, 1'b0, 1'b1, 2'd3, 32'h5A5A_A5A5);
        // Rank 0 wins, meta 0 selects a single payload bit.
        run_message(0, 1'b0);
        // A message opened by another node: this node only receives.
        send_event(OP_POLL, 1'b0, 1'b0, 1'b0, 2'd0, 32'h0);
        run_message(0, 1'b0);

        // Random part: several settings, each with a share of the events.
        // Most traffic is complete messages with random content; the rest is
        // random events that land on any phase.
        for (phase_idx = 0; phase_idx < N_SETTINGS; phase_idx++) begin
            case (phase_idx)
                0:       load_config(RANK_RST, LEN0_RST, LEN1_RST, LEN2_RST, LEN3_RST);
                1:       load_config(4'd15, 6'd32, 6'd32, 6'd32, 6'd32);
                2:       load_config(4'd0, 6'd1, 6'd1, 6'd1, 6'd1);
                default: load_config(RANK_W'($urandom_range(0, 15)), rand_len(), rand_len(),
                                     rand_len(), rand_len());
            endcase
            phase_end = (phase_idx + 1) * ITEMS_TARGET / N_SETTINGS;
            while (items_sent - noise_count < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    send_noise();
                end else begin
                    if (!sb.msg_pending && pick < 70) begin
                        send_event(OP_QUEUE, coin(), coin(), coin(),
                                   META_W'($urandom_range(0, 3)), $urandom());
                    end
                    run_message(($urandom_range(0, 3) == 0) ? 30 : 0,
                                $urandom_range(0, 2) == 0);
                end
            end
            // Settings only change between messages.
            if (sb.phase != PH_IDLE) run_message(0, 1'b0);
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Ran %0d line events over %0d settings: %0d messages, %0d sent by this node.",
                 items_sent, N_SETTINGS + 1, sb.n_messages, sb.n_sent);
        if (sb.n_errors == 0 && sb.outputs_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
